### design/rchl_pkg.sv
// Shared constants, types and helpers for the reset cause history logger.
package rchl_pkg;

  // Sizes of the stores
  localparam int unsigned HIST_DEPTH   = 8;
  localparam int unsigned REASON_COUNT = 4;
  localparam int unsigned HW           = $clog2(HIST_DEPTH);
  localparam int unsigned CW           = $clog2(REASON_COUNT);
  localparam int unsigned IW           = HW + 1;

  // Stream widths (payload rounded up to whole bytes)
  localparam int unsigned IN_BITS   = 52;
  localparam int unsigned OUT_BITS  = 99;
  localparam int unsigned IN_BYTES  = (IN_BITS + 7) / 8;
  localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int unsigned IN_TW     = IN_BYTES * 8;
  localparam int unsigned OUT_TW    = OUT_BYTES * 8;

  // Command codes
  typedef enum logic [2:0] {
    CMD_UPTIME  = 3'd0,
    CMD_EVENT   = 3'd1,
    CMD_CLR_CTX = 3'd2,
    CMD_COUNT   = 3'd3,
    CMD_TOTAL   = 3'd4,
    CMD_CLR_CNT = 3'd5,
    CMD_HIST    = 3'd6,
    CMD_CLR_ALL = 3'd7
  } cmd_e;

  // Reason codes
  localparam logic [1:0] RSN_UNKNOWN  = 2'd0;
  localparam logic [1:0] RSN_POWER_ON = 2'd1;
  localparam logic [1:0] RSN_EXTERNAL = 2'd2;
  localparam logic [1:0] RSN_WATCHDOG = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_READ,
    ST_OUT
  } state_e;

  // One input item
  typedef struct packed {
    logic [7:0]  ago;
    logic [3:0]  clear_mask;
    logic [1:0]  reason_index;
    logic [31:0] uptime_value;
    logic [2:0]  cause_flags;
    cmd_e        cmd;
  } item_t;

  // One result item
  typedef struct packed {
    logic [31:0] streak_sum;
    logic [31:0] run_uptime;
    logic [15:0] streak_len;
    logic [15:0] count;
    logic [1:0]  reason;
    logic        status;
  } result_t;

  // One history record
  typedef struct packed {
    logic [1:0]  reason;
    logic [15:0] streak_len;
    logic [31:0] run_uptime;
    logic [31:0] streak_sum;
  } hist_rec_t;

  localparam int unsigned REC_BITS = $bits(hist_rec_t);

  // Priority decode of the cause flags: power-on, then external, then watchdog
  function automatic logic [1:0] decode_cause(input logic [2:0] flags);
    logic [1:0] c;
    if (flags[0]) begin
      c = RSN_POWER_ON;
    end else if (flags[1]) begin
      c = RSN_EXTERNAL;
    end else if (flags[2]) begin
      c = RSN_WATCHDOG;
    end else begin
      c = RSN_UNKNOWN;
    end
    return c;
  endfunction

endpackage

### design/reset_cause_history_logger.sv
// Top level: reset cause history logger with counter and history memories.
//
//  Channel | Dir | Group        | Content
//  --------+-----+--------------+----------------------------------------------
//  input   | in  | s_axis_*     | one command item per transfer
//  result  | out | m_axis_*     | exactly one result item per command
//
// Steps: context and clear commands, and a history read of the current run or
// beyond the ring, go from issue straight to output; a count, reset event or
// ring history read makes one memory read, and the total reads the counter
// memory one entry per cycle.
// Reset clears the context, the valid bits of both memories and the ring head
// at once; no clearing pass. A stalled result sits in the output register; the
// next item is taken meanwhile and waits in the last step until it is free.
module reset_cause_history_logger (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] cmd, [5:3] cause_flags, [37:6] uptime_value, [39:38] reason_index,
  // [43:40] clear_mask, [51:44] ago, upper bits zero
  input  logic [rchl_pkg::IN_TW-1:0]     s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] status, [2:1] reason, [18:3] count, [34:19] streak_len,
  // [66:35] run_uptime, [98:67] streak_sum, upper bits zero
  output logic [rchl_pkg::OUT_TW-1:0]    m_axis_tdata
);
  import rchl_pkg::*;

  state_e state_q, state_d;

  item_t   item_q, item_d;
  result_t res_q, res_d;
  result_t mres_q;
  logic    m_valid_q, m_valid_d;
  logic    out_load;

  // Run context
  logic        ctx_valid_q, ctx_valid_d;
  logic [31:0] cur_up_q, cur_up_d;
  logic [15:0] cur_sc_q, cur_sc_d;
  logic [31:0] cur_su_q, cur_su_d;
  logic [15:0] prev_sc_q, prev_sc_d;
  logic [31:0] prev_up_q, prev_up_d;
  logic [31:0] prev_su_q, prev_su_d;
  logic [1:0]  last_cause_q, last_cause_d;

  // Memory bookkeeping
  logic [REASON_COUNT-1:0] cvld_q, cvld_d;
  logic [HIST_DEPTH-1:0]   hvld_q, hvld_d;
  logic [HW-1:0]           first_q, first_d;
  logic [CW:0]             rptr_q, rptr_d;
  logic [15:0]             sum_q, sum_d;
  logic                    rok_q, rok_d;

  // Memory ports
  logic          cnt_we, cnt_re;
  logic [CW-1:0] cnt_waddr, cnt_raddr;
  logic [15:0]   cnt_wdata, cnt_rdata;
  logic          hist_we, hist_re;
  logic [HW-1:0] hist_waddr, hist_raddr;
  hist_rec_t     hist_wdata, hist_rdata;

  // Helpers
  logic [1:0]  cause;
  logic [15:0] cval;
  logic [IW-1:0] hdiff;
  logic [HW-1:0] hidx;
  logic [HW-1:0] next_slot;
  logic        too_far;

  item_t in_item;
  assign in_item = item_t'(s_axis_tdata[IN_BITS-1:0]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  assign cause = decode_cause(item_q.cause_flags);
  assign cval  = rok_q ? cnt_rdata : 16'd0;

  // Ring index of the record ago older than the newest one
  assign too_far = ({1'b0, item_q.ago} + 9'd1) >= 9'(HIST_DEPTH);
  assign hdiff   = {1'b0, first_q} + IW'(HIST_DEPTH - 1) - item_q.ago[IW-1:0];
  assign hidx    = (hdiff >= IW'(HIST_DEPTH)) ? HW'(hdiff - IW'(HIST_DEPTH)) : HW'(hdiff);
  assign next_slot = (first_q == HW'(HIST_DEPTH - 1)) ? '0 : first_q + HW'(1);

  rchl_ram #(
    .WIDTH (16),
    .DEPTH (REASON_COUNT),
    .AW    (CW)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  rchl_ram #(
    .WIDTH (REC_BITS),
    .DEPTH (HIST_DEPTH),
    .AW    (HW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (item_q.cmd) inside
          CMD_EVENT, CMD_COUNT, CMD_TOTAL: state_d = ST_READ;
          CMD_HIST: begin
            state_d = (item_q.ago == 8'd0 || too_far) ? ST_OUT : ST_READ;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_READ: begin
        if (item_q.cmd != CMD_TOTAL || rptr_q == (CW + 1)'(REASON_COUNT)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    item_d       = item_q;
    res_d        = res_q;
    ctx_valid_d  = ctx_valid_q;
    cur_up_d     = cur_up_q;
    cur_sc_d     = cur_sc_q;
    cur_su_d     = cur_su_q;
    prev_sc_d    = prev_sc_q;
    prev_up_d    = prev_up_q;
    prev_su_d    = prev_su_q;
    last_cause_d = last_cause_q;
    cvld_d       = cvld_q;
    hvld_d       = hvld_q;
    first_d      = first_q;
    rptr_d       = rptr_q;
    sum_d        = sum_q;
    rok_d        = rok_q;
    cnt_we       = 1'b0;
    cnt_waddr    = CW'(cause);
    cnt_wdata    = cval + 16'd1;
    cnt_re       = 1'b0;
    cnt_raddr    = CW'(cause);
    hist_we      = 1'b0;
    hist_waddr   = first_q;
    hist_wdata   = '{reason: cause, streak_len: prev_sc_q,
                     run_uptime: prev_up_q, streak_sum: prev_su_q};
    hist_re      = 1'b0;
    hist_raddr   = hidx;
    m_valid_d    = m_valid_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          item_d = in_item;
        end
      end
      ST_ISSUE: begin
        res_d = '0;
        case (item_q.cmd)
          CMD_UPTIME: begin
            cur_up_d    = item_q.uptime_value;
            ctx_valid_d = 1'b1;
          end
          CMD_EVENT: begin
            last_cause_d = cause;
            if (ctx_valid_q) begin
              cur_su_d  = cur_su_q + cur_up_q;
              cur_sc_d  = cur_sc_q + 16'd1;
              prev_su_d = cur_su_q + cur_up_q;
              prev_sc_d = cur_sc_q + 16'd1;
              prev_up_d = cur_up_q;
            end else begin
              cur_sc_d    = '0;
              cur_su_d    = '0;
              prev_sc_d   = '0;
              prev_up_d   = '0;
              prev_su_d   = '0;
              ctx_valid_d = 1'b1;
            end
            cur_up_d = '0;
            cnt_re   = 1'b1;
            rok_d    = cvld_q[CW'(cause)];
          end
          CMD_CLR_CTX: begin
            cur_up_d    = '0;
            cur_sc_d    = '0;
            cur_su_d    = '0;
            ctx_valid_d = 1'b1;
          end
          CMD_COUNT: begin
            cnt_re    = 1'b1;
            cnt_raddr = CW'(item_q.reason_index);
            rok_d     = cvld_q[CW'(item_q.reason_index)];
          end
          CMD_TOTAL: begin
            cnt_re    = 1'b1;
            cnt_raddr = '0;
            rok_d     = cvld_q[0];
            rptr_d    = (CW + 1)'(1);
            sum_d     = '0;
          end
          CMD_CLR_CNT: begin
            for (int i = 0; i < 4; i++) begin
              if (item_q.clear_mask[i]) begin
                cvld_d[i] = 1'b0;
              end
            end
          end
          CMD_HIST: begin
            if (item_q.ago == 8'd0) begin
              res_d.reason     = last_cause_q;
              res_d.streak_len = prev_sc_q;
              res_d.run_uptime = prev_up_q;
              res_d.streak_sum = prev_su_q;
            end else if (too_far) begin
              res_d.status = 1'b1;
            end else begin
              hist_re = 1'b1;
              rok_d   = hvld_q[hidx];
            end
          end
          default: begin
            cvld_d  = '0;
            hvld_d  = '0;
            first_d = '0;
          end
        endcase
      end
      ST_READ: begin
        case (item_q.cmd)
          CMD_EVENT: begin
            // Count the cause, then append the record of the run that ended unless the cause is unknown
            cnt_we = 1'b1;
            cvld_d[CW'(cause)] = 1'b1;
            if (cause != RSN_UNKNOWN) begin
              hist_we           = 1'b1;
              hvld_d[first_q]   = 1'b1;
              hvld_d[next_slot] = 1'b0;
              first_d           = next_slot;
            end
            res_d.reason     = cause;
            res_d.streak_len = prev_sc_q;
            res_d.run_uptime = prev_up_q;
            res_d.streak_sum = prev_su_q;
          end
          CMD_COUNT: begin
            res_d.count = cval;
          end
          CMD_TOTAL: begin
            sum_d       = sum_q + cval;
            res_d.count = sum_q + cval;
            if (rptr_q != (CW + 1)'(REASON_COUNT)) begin
              cnt_re    = 1'b1;
              cnt_raddr = rptr_q[CW-1:0];
              rok_d     = cvld_q[rptr_q[CW-1:0]];
              rptr_d    = rptr_q + (CW + 1)'(1);
            end
          end
          default: begin
            // History read
            if (rok_q) begin
              res_d.reason     = hist_rdata.reason;
              res_d.streak_len = hist_rdata.streak_len;
              res_d.run_uptime = hist_rdata.run_uptime;
              res_d.streak_sum = hist_rdata.streak_sum;
            end else begin
              res_d.status = 1'b1;
            end
          end
        endcase
      end
      default: ;
    endcase

    // Output register
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // Control state and context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      m_valid_q    <= 1'b0;
      ctx_valid_q  <= 1'b0;
      cur_up_q     <= '0;
      cur_sc_q     <= '0;
      cur_su_q     <= '0;
      prev_sc_q    <= '0;
      prev_up_q    <= '0;
      prev_su_q    <= '0;
      last_cause_q <= RSN_UNKNOWN;
      cvld_q       <= '0;
      hvld_q       <= '0;
      first_q      <= '0;
      rptr_q       <= '0;
    end else begin
      state_q      <= state_d;
      m_valid_q    <= m_valid_d;
      ctx_valid_q  <= ctx_valid_d;
      cur_up_q     <= cur_up_d;
      cur_sc_q     <= cur_sc_d;
      cur_su_q     <= cur_su_d;
      prev_sc_q    <= prev_sc_d;
      prev_up_q    <= prev_up_d;
      prev_su_q    <= prev_su_d;
      last_cause_q <= last_cause_d;
      cvld_q       <= cvld_d;
      hvld_q       <= hvld_d;
      first_q      <= first_d;
      rptr_q       <= rptr_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    sum_q  <= sum_d;
    rok_q  <= rok_d;
    if (out_load) begin
      mres_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TW - OUT_BITS){1'b0}}, mres_q};

endmodule

### design/rchl_ram.sv
// Generic single-port-write, single-port-read memory with registered read data.
module rchl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
